/* sv/stack_machine_executor_top_defines.svh */
// Assertion macros used by the checker of the stack executor.
`ifndef STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SME_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("stack executor check failed");

// Checks that a condition is followed in the next cycle by a consequence.
`define SME_ASSERT_NEXT(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("stack executor sequence check failed");

`endif

/* sv/sme_pkg.sv */
package sme_pkg;

   localparam int REQ_W = 72;
   localparam int WORD_W = 64;
   localparam int PTR_W = 16;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_JUMP = 3'd5,
      OP_HALT = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_OVERFLOW  = 3'd1,
      ERR_UNDERFLOW = 3'd2,
      ERR_ILLEGAL   = 3'd3,
      ERR_DIVZERO   = 3'd4
   } err_type;

   typedef struct packed {
      logic    load;
      logic    rd_en;
      logic    unit_start;
      logic    unit_div;
      logic    commit;
      op_type  op;
      err_type err;
   } sme_cmd_type;

   typedef struct packed {
      logic full;
      logic lt2;
      logic tos_zero;
      logic unit_done;
      logic out_busy;
   } sme_status_type;

endpackage

/* sv/sme_muldiv.sv */
module sme_muldiv import sme_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              is_div,
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   output logic              done,
   output logic [WORD_W-1:0] result
);

   logic              busy_ff, busy_in;
   logic              div_ff, div_in;
   logic              done_ff, done_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic              neg_ff, neg_in;
   logic [WORD_W-1:0] res_ff, res_in;
   logic [31:0]       mx, my;
   logic [WORD_W-1:0] rem_s;
   logic [WORD_W-1:0] q_s;

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      mx      = x_ff[31:0];
      my      = y_ff[31:0];
      rem_s   = {acc_ff[WORD_W-2:0], x_ff[WORD_W-1]};
      q_s     = {x_ff[WORD_W-2:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         div_in  = is_div;
         cnt_in  = 7'd0;
         acc_in  = '0;
         if (is_div) begin
            // Divide works on magnitudes; the sign is restored at the end.
            x_in   = a[WORD_W-1] ? (WORD_W'(0) - a) : a;
            y_in   = b[WORD_W-1] ? (WORD_W'(0) - b) : b;
            neg_in = a[WORD_W-1] ^ b[WORD_W-1];
         end else begin
            x_in = a;
            y_in = b;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (div_ff) begin
            // One restoring step per cycle: acc is the remainder, x the quotient.
            if (rem_s >= y_ff) begin
               acc_in = rem_s - y_ff;
               x_in   = {q_s[WORD_W-1:1], 1'b1};
            end else begin
               acc_in = rem_s;
               x_in   = q_s;
            end
            if (cnt_ff == 7'd63) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = neg_ff ? (WORD_W'(0) - x_in) : x_in;
            end
         end else begin
            // Low 64 bits of the product from three 32x32 partial products.
            unique case (cnt_ff[1:0])
               2'd0: begin
                  mx = x_ff[31:0];
                  my = y_ff[31:0];
               end
               2'd1: begin
                  mx = x_ff[31:0];
                  my = y_ff[63:32];
                  acc_in = prod_ff;
               end
               2'd2: begin
                  mx = x_ff[63:32];
                  my = y_ff[31:0];
                  acc_in = acc_ff + {prod_ff[31:0], 32'd0};
               end
               default: begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  res_in  = acc_ff + {prod_ff[31:0], 32'd0};
               end
            endcase
            prod_in = {32'd0, mx} * {32'd0, my};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* sv/sme_datapath.sv */
module sme_datapath import sme_pkg::*; #(
   parameter int STACK_DEPTH = 1024,
   localparam int CW = $clog2(STACK_DEPTH + 1),
   localparam int AW = $clog2(STACK_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  sme_cmd_type       cmd,
   input  logic [WORD_W-1:0] req_operand,
   input  logic              rsp_ready,
   output sme_status_type    status,
   output logic              rsp_valid,
   output logic [2:0]        rsp_error,
   output logic [WORD_W-1:0] rsp_top,
   output logic [CW-1:0]     rsp_count,
   output logic [PTR_W-1:0]  rsp_ptr
);

   // The top entry lives in tos_ff; the memory holds the entries below it.
   logic [WORD_W-1:0] mem [STACK_DEPTH];
   logic [WORD_W-1:0] operand_ff;
   logic [WORD_W-1:0] tos_ff, tos_in;
   logic [CW-1:0]     depth_ff, depth_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [WORD_W-1:0] rd_ff;
   logic              wr_en;
   logic [CW-1:0]     dm1, dm2;
   logic              md_done;
   logic [WORD_W-1:0] md_result;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_error_ff;
   logic [WORD_W-1:0] rsp_top_ff;
   logic [CW-1:0]     rsp_count_ff;
   logic [PTR_W-1:0]  rsp_ptr_ff;

   assign dm1 = depth_ff - CW'(1);
   assign dm2 = depth_ff - CW'(2);

   sme_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.unit_start),
      .is_div (cmd.unit_div),
      .a      (rd_ff),
      .b      (tos_ff),
      .done   (md_done),
      .result (md_result)
   );

   always_comb begin
      tos_in   = tos_ff;
      depth_in = depth_ff;
      ptr_in   = ptr_ff;
      wr_en    = 1'b0;
      if (cmd.err == ERR_OK) begin
         ptr_in = ptr_ff + PTR_W'(1);
         unique case (cmd.op)
            OP_PUSH: begin
               tos_in   = operand_ff;
               depth_in = depth_ff + CW'(1);
               wr_en    = (depth_ff != '0);
            end
            OP_ADD: begin
               tos_in   = rd_ff + tos_ff;
               depth_in = dm1;
            end
            OP_SUB: begin
               tos_in   = rd_ff - tos_ff;
               depth_in = dm1;
            end
            OP_MUL, OP_DIV: begin
               tos_in   = md_result;
               depth_in = dm1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            depth_ff     <= depth_in;
            ptr_ff       <= ptr_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load) begin
         operand_ff <= req_operand;
      end
      if (cmd.commit) begin
         tos_ff       <= tos_in;
         rsp_error_ff <= cmd.err;
         rsp_top_ff   <= (depth_in != '0) ? tos_in : '0;
         rsp_count_ff <= depth_in;
         rsp_ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         mem[dm1[AW-1:0]] <= tos_ff;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[dm2[AW-1:0]];
      end
   end

   assign status.full      = (depth_ff >= CW'(STACK_DEPTH));
   assign status.lt2       = (depth_ff < CW'(2));
   assign status.tos_zero  = (tos_ff == '0);
   assign status.unit_done = md_done;
   assign status.out_busy  = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_error = rsp_error_ff;
   assign rsp_top   = rsp_top_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_ptr   = rsp_ptr_ff;

endmodule

/* sv/sme_ctrl.sv */
module sme_ctrl import sme_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [2:0]     req_mode,
   output logic           req_ready,
   input  sme_status_type status,
   output sme_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_EXEC,
      ST_FIN
   } state_type;

   state_type state_ff;
   op_type    op_ff;
   err_type   err_ff;
   op_type    mode_op;
   err_type   dec_err;
   logic      accept;
   logic      binary;

   assign mode_op = op_type'(req_mode);
   assign accept  = req_valid && (state_ff == ST_IDLE);
   assign binary  = (mode_op == OP_ADD) || (mode_op == OP_SUB) ||
                    (mode_op == OP_MUL) || (mode_op == OP_DIV);

   // All error cases are known from the opcode and the stack state when the transaction arrives.
   always_comb begin
      unique case (mode_op)
         OP_PUSH:               dec_err = status.full ? ERR_OVERFLOW : ERR_OK;
         OP_ADD, OP_SUB, OP_MUL: dec_err = status.lt2 ? ERR_UNDERFLOW : ERR_OK;
         OP_DIV: begin
            if (status.lt2) begin
               dec_err = ERR_UNDERFLOW;
            end else if (status.tos_zero) begin
               dec_err = ERR_DIVZERO;
            end else begin
               dec_err = ERR_OK;
            end
         end
         OP_JUMP:               dec_err = ERR_OK;
         default:               dec_err = ERR_ILLEGAL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_JUMP;
         err_ff   <= ERR_OK;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff  <= mode_op;
                  err_ff <= dec_err;
                  if (binary && dec_err == ERR_OK &&
                      (mode_op == OP_MUL || mode_op == OP_DIV)) begin
                     state_ff <= ST_START;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_START: state_ff <= ST_EXEC;
            ST_EXEC: begin
               if (status.unit_done) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign cmd.load       = accept;
   assign cmd.rd_en      = accept && binary && (dec_err == ERR_OK);
   assign cmd.unit_start = (state_ff == ST_START);
   assign cmd.unit_div   = (op_ff == OP_DIV);
   assign cmd.commit     = (state_ff == ST_FIN) && !status.out_busy;
   assign cmd.op         = op_ff;
   assign cmd.err        = err_ff;

endmodule

/* sv/stack_machine_executor_top.sv */
// Push, jump, add, subtract and every error case go from acceptance to the result state
// (the stack memory read overlaps the acceptance cycle); multiply first forms three
// 32x32 partial products in the unit before that state, and divide one quotient bit per cycle.
// Throughput: one transaction in flight; the next is taken the cycle after the result is
// loaded into the output register. Synchronous active-high reset empties the stack and
// zeroes the pointer; memory is not cleared.
module stack_machine_executor_top import sme_pkg::*; #(
   parameter int STACK_DEPTH = 1024,
   localparam int CW = $clog2(STACK_DEPTH + 1),
   localparam int RSP_BITS = 3 + WORD_W + CW + PTR_W,
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // mode[2:0], operand[66:3]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // error_code, top_value, stack_count, instr_pointer
);

   sme_cmd_type       cmd;
   sme_status_type    status;
   logic [2:0]        rsp_error;
   logic [WORD_W-1:0] rsp_top;
   logic [CW-1:0]     rsp_count;
   logic [PTR_W-1:0]  rsp_ptr;

   sme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tdata[2:0]),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sme_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_operand (req_tdata[66:3]),
      .rsp_ready   (rsp_tready),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_error   (rsp_error),
      .rsp_top     (rsp_top),
      .rsp_count   (rsp_count),
      .rsp_ptr     (rsp_ptr)
   );

   assign rsp_tdata = RSP_W'({rsp_ptr, rsp_count, rsp_top, rsp_error});

endmodule

/* sv/sme_checker.sv */
`include "stack_machine_executor_top_defines.svh"

module sme_checker import sme_pkg::*; #(
   parameter int STACK_DEPTH = 1024,
   localparam int CW = $clog2(STACK_DEPTH + 1),
   localparam int RSP_W = (((3 + WORD_W + CW + PTR_W) + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [2:0]        chk_err;
   logic [WORD_W-1:0] chk_top;
   logic [CW-1:0]     chk_count;

   assign chk_err   = rsp_tdata[2:0];
   assign chk_top   = rsp_tdata[66:3];
   assign chk_count = rsp_tdata[67 + CW - 1:67];

   `SME_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SME_ASSERT(a_count_range, !rsp_tvalid || (chk_count <= CW'(STACK_DEPTH)))
   `SME_ASSERT(a_err_range, !rsp_tvalid || (chk_err <= 3'd4))
   `SME_ASSERT(a_empty_top, !(rsp_tvalid && chk_count == '0) || (chk_top == '0))

endmodule

bind stack_machine_executor_top sme_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sme_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import sme_pkg::*;

   localparam int DEPTH = 1024;
   localparam int CNT_W = 11;
   localparam int RSP_W = 96;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      err_type     err;
      logic [63:0] top;
      logic [CNT_W-1:0] count;
      logic [15:0] ptr;
   } exec_result_type;

   // Shadow of the executor: its own stack, depth and pointer, plus the
   // results still owed by the block.
   class stack_shadow;
      logic [63:0] stack_mem [DEPTH];
      int unsigned depth;
      logic [15:0] ptr;
      exec_result_type expected_results[$];
      int unsigned mismatches;

      function new();
         depth = 0;
         ptr = '0;
         mismatches = 0;
      endfunction

      function logic [63:0] signed_quotient(logic [63:0] a, logic [63:0] b);
         logic [63:0] ma, mb, q;
         ma = a[63] ? -a : a;
         mb = b[63] ? -b : b;
         q = ma / mb;
         return (a[63] != b[63]) ? -q : q;
      endfunction

      function void note_instr(logic [2:0] mode, logic [63:0] operand);
         err_type err;
         logic [63:0] a, b, r;
         exec_result_type res;
         err = ERR_OK;
         r = '0;
         case (mode)
            OP_PUSH: begin
               if (depth >= DEPTH) begin
                  err = ERR_OVERFLOW;
               end else begin
                  stack_mem[depth] = operand;
                  depth++;
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (depth < 2) begin
                  err = ERR_UNDERFLOW;
               end else begin
                  a = stack_mem[depth-2];
                  b = stack_mem[depth-1];
                  case (mode)
                     OP_ADD: r = a + b;
                     OP_SUB: r = a - b;
                     OP_MUL: r = a * b;
                     default: begin
                        if (b == '0) err = ERR_DIVZERO;
                        else r = signed_quotient(a, b);
                     end
                  endcase
                  if (err == ERR_OK) begin
                     stack_mem[depth-2] = r;
                     depth--;
                  end
               end
            end
            OP_JUMP: ;
            default: err = ERR_ILLEGAL;
         endcase
         if (err == ERR_OK) ptr = ptr + 16'd1;
         res.err = err;
         res.top = (depth > 0) ? stack_mem[depth-1] : '0;
         res.count = CNT_W'(depth);
         res.ptr = ptr;
         expected_results.push_back(res);
      endfunction

      function void check_result(logic [RSP_W-1:0] data);
         exec_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %h", data);
            return;
         end
         want = expected_results.pop_front();
         if (data[2:0] !== want.err || data[66:3] !== want.top ||
             data[77:67] !== want.count || data[93:78] !== want.ptr) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected err=%0d top=%h cnt=%0d ip=%0d",
                        want.err, want.top, want.count, want.ptr,
                        ", got err=%0d top=%h cnt=%0d ip=%0d",
                        data[2:0], data[66:3], data[77:67], data[93:78]);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   stack_shadow shadow = new();
   int unsigned send_idle_pct = 20;
   int unsigned recv_idle_pct = 46;
   int unsigned hold_cycles = 0;
   int unsigned quiet_cycles = 0;
   int unsigned gen_depth = 0;

   stack_machine_executor_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor, scoreboard hookup and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            shadow.note_instr(req_tdata[2:0], req_tdata[66:3]);
         end
         if (rsp_tvalid && rsp_tready) begin
            shadow.check_result(rsp_tdata);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: random backpressure, or a long hold-off when requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_instr(logic [2:0] mode, logic [63:0] operand);
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, operand, mode};
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] pick_word();
      case ($urandom_range(5))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return 64'(signed'($urandom_range(40)) - 20);
         3: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Random instruction with a bias that keeps the stack shallow but busy.
   task automatic send_random();
      int unsigned roll;
      logic [2:0] mode;
      roll = $urandom_range(99);
      if (gen_depth < 2 && roll < 85) mode = OP_PUSH;
      else if (roll < 40 && gen_depth < 40) mode = OP_PUSH;
      else if (roll < 88) mode = 3'($urandom_range(OP_DIV, OP_ADD));
      else if (roll < 95) mode = OP_JUMP;
      else mode = $urandom_range(1) ? OP_HALT : OP_UNUSED;
      if (mode == OP_PUSH && gen_depth < DEPTH) gen_depth++;
      else if (mode >= OP_ADD && mode <= OP_DIV && gen_depth >= 2) gen_depth--;
      send_instr(mode, pick_word());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: underflow on empty stack, wrapping arithmetic, divide cases,
      // jump and the illegal opcodes.
      send_instr(OP_ADD, '1);
      send_instr(OP_DIV, '0);
      send_instr(OP_PUSH, MOST_POS);
      send_instr(OP_SUB, '0);
      send_instr(OP_PUSH, MOST_NEG);
      send_instr(OP_ADD, '0);
      send_instr(OP_PUSH, MOST_POS);
      send_instr(OP_MUL, '0);
      send_instr(OP_PUSH, MOST_NEG);
      send_instr(OP_PUSH, '1);
      send_instr(OP_DIV, '0);
      send_instr(OP_PUSH, 64'd0);
      send_instr(OP_DIV, '0);
      send_instr(OP_PUSH, -64'sd7);
      send_instr(OP_PUSH, 64'd2);
      send_instr(OP_DIV, '0);
      send_instr(OP_PUSH, MOST_NEG);
      send_instr(OP_SUB, '0);
      send_instr(OP_JUMP, '1);
      send_instr(OP_HALT, MOST_POS);
      send_instr(OP_UNUSED, MOST_NEG);
      gen_depth = 6;

      repeat (60) send_random();

      send_idle_pct = 46;
      recv_idle_pct = 20;
      // Long receiver hold-off while the sender keeps offering.
      hold_cycles = 400;
      repeat (60) send_random();

      // Fill the stack to the top and push past it to hit overflow.
      repeat (DEPTH + 4 - shadow.depth) send_instr(OP_PUSH, pick_word());
      gen_depth = DEPTH;

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (60) send_random();

      req_tvalid <= 1'b0;
      while (shadow.expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
